/* src/miu_pkg.sv */
// ----------------------------------------------------------------------------
// MIPS integer execute unit package
// Shared types, opcodes and codes for the execute unit modules.
// ----------------------------------------------------------------------------
package miu_pkg;

    localparam int unsigned XLEN     = 32;
    localparam int unsigned NUM_REGS = 32;
    localparam int unsigned RIDX_W   = 5;

    // Trap codes reported with each result word.
    localparam logic [2:0] TRAP_NONE      = 3'd0;
    localparam logic [2:0] TRAP_OVERFLOW  = 3'd1;
    localparam logic [2:0] TRAP_SYSCALL   = 3'd2;
    localparam logic [2:0] TRAP_BREAK     = 3'd3;
    localparam logic [2:0] TRAP_RESERVED  = 3'd4;
    localparam logic [2:0] TRAP_COP       = 3'd5;
    localparam logic [2:0] TRAP_MISALIGN  = 3'd6;

    // Primary opcodes.
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0a;
    localparam logic [5:0] OP_SLTIU   = 6'h0b;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_ORI     = 6'h0d;
    localparam logic [5:0] OP_XORI    = 6'h0e;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_COP1    = 6'h11;
    localparam logic [5:0] OP_COP3    = 6'h13;
    localparam logic [5:0] OP_BEQL    = 6'h14;
    localparam logic [5:0] OP_BNEL    = 6'h15;
    localparam logic [5:0] OP_BLEZL   = 6'h16;
    localparam logic [5:0] OP_BGTZL   = 6'h17;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LWL     = 6'h22;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_LWR     = 6'h26;
    localparam logic [5:0] OP_LWU     = 6'h27;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SWL     = 6'h2a;
    localparam logic [5:0] OP_SW      = 6'h2b;
    localparam logic [5:0] OP_SWR     = 6'h2e;
    localparam logic [5:0] OP_CACHE   = 6'h2f;
    localparam logic [5:0] OP_LWC1    = 6'h31;
    localparam logic [5:0] OP_LWC2    = 6'h32;
    localparam logic [5:0] OP_LWC3    = 6'h33;
    localparam logic [5:0] OP_SWC1    = 6'h39;
    localparam logic [5:0] OP_SWC2    = 6'h3a;
    localparam logic [5:0] OP_SWC3    = 6'h3b;

    // SPECIAL function codes.
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_SLLV    = 6'h04;
    localparam logic [5:0] FN_SRLV    = 6'h06;
    localparam logic [5:0] FN_SRAV    = 6'h07;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_SYSCALL = 6'h0c;
    localparam logic [5:0] FN_BREAK   = 6'h0d;
    localparam logic [5:0] FN_SYNC    = 6'h0f;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MTHI    = 6'h11;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MTLO    = 6'h13;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_MULTU   = 6'h19;
    localparam logic [5:0] FN_DIV     = 6'h1a;
    localparam logic [5:0] FN_DIVU    = 6'h1b;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2a;
    localparam logic [5:0] FN_SLTU    = 6'h2b;

    localparam logic [RIDX_W-1:0] LINK_REG = 5'd31;

    // Command to the multiply/divide unit.
    typedef struct packed {
        logic start;
        logic is_div;
        logic is_signed;
    } md_cmd_t;

    // Everything the execute logic decides for one instruction word.
    typedef struct packed {
        logic             reg_write;
        logic [4:0]       write_index;
        logic [XLEN-1:0]  write_value;
        logic             jump_taken;
        logic [XLEN-1:0]  jump_target;
        logic             skip_delay_slot;
        logic [2:0]       trap_code;
        logic [XLEN-1:0]  mem_address;
        logic             hi_we;
        logic             lo_we;
        md_cmd_t          md;
    } exec_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RS,
        ST_RT,
        ST_EXEC,
        ST_MD,
        ST_OUT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_RUN,
        MD_FIX,
        MD_DONE
    } md_state_t;

endpackage

/* src/miu_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module miu_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/miu_alu.sv */
// ----------------------------------------------------------------------------
// Execute logic
// Decodes one instruction word and works out writes, branches and traps.
// ----------------------------------------------------------------------------
module miu_alu (
    input  logic [31:0]        instr,
    input  logic [31:0]        pc,
    input  logic [31:0]        x,
    input  logic [31:0]        y,
    input  logic [31:0]        hi,
    input  logic [31:0]        lo,
    output miu_pkg::exec_res_t res
);

    logic [5:0]  op;
    logic [5:0]  funct;
    logic [4:0]  rt_f;
    logic [4:0]  rd_f;
    logic [4:0]  sa_f;
    logic [4:0]  sh_amt;
    logic [15:0] imm;
    logic [31:0] sx;
    logic [31:0] zx;
    logic [31:0] pc4;
    logic [31:0] pc8;
    logic [31:0] btgt;
    logic [31:0] jtgt;
    logic [31:0] addr;
    logic [31:0] sum_xy;
    logic [31:0] dif_xy;
    logic [31:0] sum_xi;
    logic        ovf_add;
    logic        ovf_sub;
    logic        ovf_addi;
    logic        x_neg;
    logic        x_zero;
    logic        wr_req;
    logic [4:0]  wr_idx;
    logic [31:0] wr_val;
    logic        br_cond;
    logic        br_en;
    logic        br_likely;

    assign op     = instr[31:26];
    assign rt_f   = instr[20:16];
    assign rd_f   = instr[15:11];
    assign sa_f   = instr[10:6];
    assign funct  = instr[5:0];
    assign imm    = instr[15:0];
    assign sx     = {{16{imm[15]}}, imm};
    assign zx     = {16'h0000, imm};
    assign pc4    = pc + 32'd4;
    assign pc8    = pc + 32'd8;
    assign btgt   = pc4 + {sx[29:0], 2'b00};
    assign jtgt   = {pc4[31:28], instr[25:0], 2'b00};
    assign addr   = x + sx;
    assign sum_xy = x + y;
    assign dif_xy = x - y;
    assign sum_xi = x + sx;
    assign sh_amt = funct[2] ? x[4:0] : sa_f;
    assign x_neg  = x[31];
    assign x_zero = (x == 32'd0);

    assign ovf_add  = ((x ^ sum_xy) & (y ^ sum_xy)) >> 31 != 32'd0;
    assign ovf_sub  = ((x ^ y) & (x ^ dif_xy)) >> 31 != 32'd0;
    assign ovf_addi = ((x ^ sum_xi) & (sx ^ sum_xi)) >> 31 != 32'd0;

    always_comb
    begin
        res       = '0;
        wr_req    = 1'b0;
        wr_idx    = rt_f;
        wr_val    = 32'd0;
        br_en     = 1'b0;
        br_cond   = 1'b0;
        br_likely = 1'b0;
        unique case (op)
            miu_pkg::OP_SPECIAL:
            begin
                wr_idx = rd_f;
                unique case (funct)
                    miu_pkg::FN_SLL, miu_pkg::FN_SLLV:
                    begin
                        wr_req = 1'b1;
                        wr_val = y << sh_amt;
                    end
                    miu_pkg::FN_SRL, miu_pkg::FN_SRLV:
                    begin
                        wr_req = 1'b1;
                        wr_val = y >> sh_amt;
                    end
                    miu_pkg::FN_SRA, miu_pkg::FN_SRAV:
                    begin
                        wr_req = 1'b1;
                        wr_val = $unsigned($signed(y) >>> sh_amt);
                    end
                    miu_pkg::FN_JR:
                    begin
                        res.jump_taken  = 1'b1;
                        res.jump_target = x;
                    end
                    miu_pkg::FN_JALR:
                    begin
                        res.jump_taken  = 1'b1;
                        res.jump_target = x;
                        wr_req          = 1'b1;
                        wr_val          = pc8;
                    end
                    miu_pkg::FN_SYSCALL: res.trap_code = miu_pkg::TRAP_SYSCALL;
                    miu_pkg::FN_BREAK:   res.trap_code = miu_pkg::TRAP_BREAK;
                    miu_pkg::FN_SYNC:    res.trap_code = miu_pkg::TRAP_NONE;
                    miu_pkg::FN_MFHI:
                    begin
                        wr_req = 1'b1;
                        wr_val = hi;
                    end
                    miu_pkg::FN_MTHI:    res.hi_we = 1'b1;
                    miu_pkg::FN_MFLO:
                    begin
                        wr_req = 1'b1;
                        wr_val = lo;
                    end
                    miu_pkg::FN_MTLO:    res.lo_we = 1'b1;
                    miu_pkg::FN_MULT, miu_pkg::FN_MULTU,
                    miu_pkg::FN_DIV, miu_pkg::FN_DIVU:
                    begin
                        res.md.start     = 1'b1;
                        res.md.is_div    = funct[1];
                        res.md.is_signed = ~funct[0];
                    end
                    miu_pkg::FN_ADD:
                    begin
                        if (ovf_add)
                        begin
                            res.trap_code = miu_pkg::TRAP_OVERFLOW;
                        end
                        else
                        begin
                            wr_req = 1'b1;
                            wr_val = sum_xy;
                        end
                    end
                    miu_pkg::FN_ADDU:
                    begin
                        wr_req = 1'b1;
                        wr_val = sum_xy;
                    end
                    miu_pkg::FN_SUB:
                    begin
                        if (ovf_sub)
                        begin
                            res.trap_code = miu_pkg::TRAP_OVERFLOW;
                        end
                        else
                        begin
                            wr_req = 1'b1;
                            wr_val = dif_xy;
                        end
                    end
                    miu_pkg::FN_SUBU:
                    begin
                        wr_req = 1'b1;
                        wr_val = dif_xy;
                    end
                    miu_pkg::FN_AND:
                    begin
                        wr_req = 1'b1;
                        wr_val = x & y;
                    end
                    miu_pkg::FN_OR:
                    begin
                        wr_req = 1'b1;
                        wr_val = x | y;
                    end
                    miu_pkg::FN_XOR:
                    begin
                        wr_req = 1'b1;
                        wr_val = x ^ y;
                    end
                    miu_pkg::FN_NOR:
                    begin
                        wr_req = 1'b1;
                        wr_val = ~(x | y);
                    end
                    miu_pkg::FN_SLT:
                    begin
                        wr_req = 1'b1;
                        wr_val = {31'd0, $signed(x) < $signed(y)};
                    end
                    miu_pkg::FN_SLTU:
                    begin
                        wr_req = 1'b1;
                        wr_val = {31'd0, x < y};
                    end
                    default: res.trap_code = miu_pkg::TRAP_RESERVED;
                endcase
            end
            miu_pkg::OP_REGIMM:
            begin
                // Selector bits: 4 = link, 1 = likely, 0 = branch on not negative.
                if (rt_f[3:2] == 2'b00)
                begin
                    br_en     = 1'b1;
                    br_cond   = rt_f[0] ? ~x_neg : x_neg;
                    br_likely = rt_f[1];
                    wr_idx    = miu_pkg::LINK_REG;
                    wr_req    = rt_f[4];
                    wr_val    = pc8;
                end
                else
                begin
                    res.trap_code = miu_pkg::TRAP_RESERVED;
                end
            end
            miu_pkg::OP_J:
            begin
                res.jump_taken  = 1'b1;
                res.jump_target = jtgt;
            end
            miu_pkg::OP_JAL:
            begin
                res.jump_taken  = 1'b1;
                res.jump_target = jtgt;
                wr_req          = 1'b1;
                wr_idx          = miu_pkg::LINK_REG;
                wr_val          = pc8;
            end
            miu_pkg::OP_BEQ, miu_pkg::OP_BEQL:
            begin
                br_en     = 1'b1;
                br_cond   = (x == y);
                br_likely = op[4];
            end
            miu_pkg::OP_BNE, miu_pkg::OP_BNEL:
            begin
                br_en     = 1'b1;
                br_cond   = (x != y);
                br_likely = op[4];
            end
            miu_pkg::OP_BLEZ, miu_pkg::OP_BLEZL:
            begin
                br_en     = 1'b1;
                br_cond   = x_neg | x_zero;
                br_likely = op[4];
            end
            miu_pkg::OP_BGTZ, miu_pkg::OP_BGTZL:
            begin
                br_en     = 1'b1;
                br_cond   = ~x_neg & ~x_zero;
                br_likely = op[4];
            end
            miu_pkg::OP_ADDI:
            begin
                if (ovf_addi)
                begin
                    res.trap_code = miu_pkg::TRAP_OVERFLOW;
                end
                else
                begin
                    wr_req = 1'b1;
                    wr_val = sum_xi;
                end
            end
            miu_pkg::OP_ADDIU:
            begin
                wr_req = 1'b1;
                wr_val = sum_xi;
            end
            miu_pkg::OP_SLTI:
            begin
                wr_req = 1'b1;
                wr_val = {31'd0, $signed(x) < $signed(sx)};
            end
            miu_pkg::OP_SLTIU:
            begin
                wr_req = 1'b1;
                wr_val = {31'd0, x < sx};
            end
            miu_pkg::OP_ANDI:
            begin
                wr_req = 1'b1;
                wr_val = x & zx;
            end
            miu_pkg::OP_ORI:
            begin
                wr_req = 1'b1;
                wr_val = x | zx;
            end
            miu_pkg::OP_XORI:
            begin
                wr_req = 1'b1;
                wr_val = x ^ zx;
            end
            miu_pkg::OP_LUI:
            begin
                wr_req = 1'b1;
                wr_val = {imm, 16'h0000};
            end
            miu_pkg::OP_COP1, miu_pkg::OP_COP3,
            miu_pkg::OP_LWC1, miu_pkg::OP_LWC2, miu_pkg::OP_LWC3,
            miu_pkg::OP_SWC1, miu_pkg::OP_SWC2, miu_pkg::OP_SWC3:
            begin
                res.trap_code = miu_pkg::TRAP_COP;
            end
            miu_pkg::OP_LB, miu_pkg::OP_LWL, miu_pkg::OP_LBU, miu_pkg::OP_LWR,
            miu_pkg::OP_SB, miu_pkg::OP_SWL, miu_pkg::OP_SWR:
            begin
                res.mem_address = addr;
            end
            miu_pkg::OP_LH, miu_pkg::OP_LHU, miu_pkg::OP_SH:
            begin
                res.mem_address = addr;
                if (addr[0])
                begin
                    res.trap_code = miu_pkg::TRAP_MISALIGN;
                end
            end
            miu_pkg::OP_LW, miu_pkg::OP_LWU, miu_pkg::OP_SW:
            begin
                res.mem_address = addr;
                if (addr[1:0] != 2'b00)
                begin
                    res.trap_code = miu_pkg::TRAP_MISALIGN;
                end
            end
            miu_pkg::OP_CACHE: res.trap_code = miu_pkg::TRAP_NONE;
            default:           res.trap_code = miu_pkg::TRAP_RESERVED;
        endcase

        if (br_en)
        begin
            if (br_cond)
            begin
                res.jump_taken  = 1'b1;
                res.jump_target = btgt;
            end
            else
            begin
                res.skip_delay_slot = br_likely;
            end
        end

        // Writes to register zero are dropped and reported as no write.
        if (wr_req && (wr_idx != 5'd0))
        begin
            res.reg_write   = 1'b1;
            res.write_index = wr_idx;
            res.write_value = wr_val;
        end
    end

endmodule

/* src/miu_muldiv.sv */
// ----------------------------------------------------------------------------
// Iterative multiply/divide unit
// Shift-add multiply and restoring divide, one bit per cycle, on magnitudes.
// ----------------------------------------------------------------------------
module miu_muldiv (
    input  logic              clk,
    input  logic              rst_n,
    input  miu_pkg::md_cmd_t  cmd,
    input  logic [31:0]       op_a,
    input  logic [31:0]       op_b,
    output logic              done,
    output logic [31:0]       hi,
    output logic [31:0]       lo
);

    miu_pkg::md_state_t state_reg;
    miu_pkg::md_state_t state_next;

    logic [4:0]  cnt_reg;
    logic [63:0] acc_reg;
    logic [31:0] mag_reg;
    logic        div_reg;
    logic        neg_q_reg;
    logic        neg_r_reg;
    logic [31:0] hi_reg;
    logic [31:0] lo_reg;

    logic [31:0] a_mag;
    logic [31:0] b_mag;
    logic [32:0] mul_sum;
    logic [33:0] div_trial;
    logic [63:0] step_val;
    logic [63:0] prod_neg;

    assign a_mag = (cmd.is_signed && op_a[31]) ? (32'd0 - op_a) : op_a;
    assign b_mag = (cmd.is_signed && op_b[31]) ? (32'd0 - op_b) : op_b;

    assign mul_sum   = {1'b0, acc_reg[63:32]} + (acc_reg[0] ? {1'b0, mag_reg} : 33'd0);
    assign div_trial = {1'b0, acc_reg[63:31]} - {2'b00, mag_reg};
    assign prod_neg  = 64'd0 - acc_reg;

    always_comb
    begin
        if (div_reg)
        begin
            if (div_trial[33])
            begin
                step_val = {acc_reg[62:0], 1'b0};
            end
            else
            begin
                step_val = {div_trial[31:0], acc_reg[30:0], 1'b1};
            end
        end
        else
        begin
            step_val = {mul_sum, acc_reg[31:1]};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            miu_pkg::MD_IDLE: if (cmd.start) state_next = miu_pkg::MD_RUN;
            miu_pkg::MD_RUN:  if (cnt_reg == 5'd31) state_next = miu_pkg::MD_FIX;
            miu_pkg::MD_FIX:  state_next = miu_pkg::MD_DONE;
            miu_pkg::MD_DONE: state_next = miu_pkg::MD_IDLE;
            default:          state_next = miu_pkg::MD_IDLE;
        endcase
    end

    always_comb
    begin
        done = (state_reg == miu_pkg::MD_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= miu_pkg::MD_IDLE;
            cnt_reg   <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == miu_pkg::MD_RUN)
            begin
                cnt_reg <= cnt_reg + 5'd1;
            end
            else
            begin
                cnt_reg <= 5'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            miu_pkg::MD_IDLE:
            begin
                if (cmd.start)
                begin
                    div_reg   <= cmd.is_div;
                    neg_q_reg <= cmd.is_signed & (op_a[31] ^ op_b[31]);
                    neg_r_reg <= cmd.is_signed & op_a[31];
                    if (cmd.is_div)
                    begin
                        acc_reg <= {32'd0, a_mag};
                        mag_reg <= b_mag;
                    end
                    else
                    begin
                        acc_reg <= {32'd0, b_mag};
                        mag_reg <= a_mag;
                    end
                end
            end
            miu_pkg::MD_RUN:
            begin
                acc_reg <= step_val;
            end
            miu_pkg::MD_FIX:
            begin
                if (div_reg)
                begin
                    lo_reg <= neg_q_reg ? (32'd0 - acc_reg[31:0]) : acc_reg[31:0];
                    hi_reg <= neg_r_reg ? (32'd0 - acc_reg[63:32]) : acc_reg[63:32];
                end
                else
                begin
                    lo_reg <= neg_q_reg ? prod_neg[31:0] : acc_reg[31:0];
                    hi_reg <= neg_q_reg ? prod_neg[63:32] : acc_reg[63:32];
                end
            end
            miu_pkg::MD_DONE:
            begin
                acc_reg <= acc_reg;
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign hi = hi_reg;
    assign lo = lo_reg;

endmodule

/* src/mips32_integer_execute_unit.sv */
// ----------------------------------------------------------------------------
// MIPS32 integer execute unit
// Runs one instruction word against its own register file and HI/LO pair.
// ----------------------------------------------------------------------------
// The unit takes one instruction word and its PC at a time and returns one
// result word for it. For ordinary instructions the word passes through the
// RS, RT and EXEC states: the register file is a RAM with one registered
// read port, so the two source registers are read one after the other in RS
// and RT before the execute state, and the result is registered after it.
// MULT, MULTU, DIV and DIVU additionally run through the shared iterative
// multiply/divide unit, one bit per cycle. The input side is ready again in
// the cycle after the result word has been taken; the unit holds one word at
// a time and accepts no new word until the last result word is taken. After
// reset all general registers read as zero, because a valid bit per register
// masks entries that have never been written; no clearing pass is needed.
// Loads and stores only report their effective address and any alignment trap.
// ----------------------------------------------------------------------------
module mips32_integer_execute_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] instruction_word,
    input  logic [31:0] program_counter,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        reg_write,
    output logic [4:0]  write_index,
    output logic [31:0] write_value,
    output logic        jump_taken,
    output logic [31:0] jump_target,
    output logic        skip_delay_slot,
    output logic [2:0]  trap_code,
    output logic [31:0] mem_address
);

    miu_pkg::ctrl_state_t state_reg;
    miu_pkg::ctrl_state_t state_next;

    // Latched input word.
    logic [31:0] ir_reg;
    logic [31:0] pc_reg;

    // Register file read path.
    logic [4:0]  raddr;
    logic [4:0]  raddr_reg;
    logic [31:0] rf_rdata;
    logic [31:0] rf_value;
    logic [31:0] valid_reg;
    logic [31:0] x_reg;

    logic [31:0] hi_reg;
    logic [31:0] lo_reg;

    miu_pkg::exec_res_t res;
    miu_pkg::md_cmd_t   md_cmd;
    logic               md_done;
    logic [31:0]        md_hi;
    logic [31:0]        md_lo;
    logic               rf_we;

    // Result registers, held until the result word is taken.
    logic        reg_write_reg;
    logic [4:0]  write_index_reg;
    logic [31:0] write_value_reg;
    logic        jump_taken_reg;
    logic [31:0] jump_target_reg;
    logic        skip_reg;
    logic [2:0]  trap_reg;
    logic [31:0] mem_address_reg;

    // A register never written since reset reads as zero.
    assign rf_value = valid_reg[raddr_reg] ? rf_rdata : 32'd0;

    // Read source register in the RS state, target register in the RT state.
    assign raddr = (state_reg == miu_pkg::ST_RS) ? ir_reg[25:21] : ir_reg[20:16];

    assign rf_we = (state_reg == miu_pkg::ST_EXEC) && res.reg_write;

    miu_ram #(
        .WIDTH (miu_pkg::XLEN),
        .DEPTH (miu_pkg::NUM_REGS)
    ) u_regfile (
        .clk   (clk),
        .we    (rf_we),
        .waddr (res.write_index),
        .wdata (res.write_value),
        .raddr (raddr),
        .rdata (rf_rdata)
    );

    // In the execute cycle the read port delivers the target register.
    miu_alu u_alu (
        .instr (ir_reg),
        .pc    (pc_reg),
        .x     (x_reg),
        .y     (rf_value),
        .hi    (hi_reg),
        .lo    (lo_reg),
        .res   (res)
    );

    always_comb
    begin
        md_cmd       = res.md;
        md_cmd.start = res.md.start && (state_reg == miu_pkg::ST_EXEC);
    end

    miu_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (md_cmd),
        .op_a  (x_reg),
        .op_b  (rf_value),
        .done  (md_done),
        .hi    (md_hi),
        .lo    (md_lo)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            miu_pkg::ST_IDLE: if (in_valid) state_next = miu_pkg::ST_RS;
            miu_pkg::ST_RS:   state_next = miu_pkg::ST_RT;
            miu_pkg::ST_RT:   state_next = miu_pkg::ST_EXEC;
            miu_pkg::ST_EXEC:
            begin
                if (res.md.start)
                begin
                    state_next = miu_pkg::ST_MD;
                end
                else
                begin
                    state_next = miu_pkg::ST_OUT;
                end
            end
            miu_pkg::ST_MD:   if (md_done) state_next = miu_pkg::ST_OUT;
            miu_pkg::ST_OUT:  if (out_ready) state_next = miu_pkg::ST_IDLE;
            default:          state_next = miu_pkg::ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        in_ready  = (state_reg == miu_pkg::ST_IDLE);
        out_valid = (state_reg == miu_pkg::ST_OUT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= miu_pkg::ST_IDLE;
            valid_reg <= 32'd0;
            hi_reg    <= 32'd0;
            lo_reg    <= 32'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (rf_we)
            begin
                valid_reg[res.write_index] <= 1'b1;
            end
            if ((state_reg == miu_pkg::ST_EXEC) && res.hi_we)
            begin
                hi_reg <= x_reg;
            end
            if ((state_reg == miu_pkg::ST_EXEC) && res.lo_we)
            begin
                lo_reg <= x_reg;
            end
            if ((state_reg == miu_pkg::ST_MD) && md_done)
            begin
                hi_reg <= md_hi;
                lo_reg <= md_lo;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        raddr_reg <= raddr;
        if (in_valid && in_ready)
        begin
            ir_reg <= instruction_word;
            pc_reg <= program_counter;
        end
        if (state_reg == miu_pkg::ST_RT)
        begin
            x_reg <= rf_value;
        end
        if (state_reg == miu_pkg::ST_EXEC)
        begin
            reg_write_reg   <= res.reg_write;
            write_index_reg <= res.write_index;
            write_value_reg <= res.write_value;
            jump_taken_reg  <= res.jump_taken;
            jump_target_reg <= res.jump_target;
            skip_reg        <= res.skip_delay_slot;
            trap_reg        <= res.trap_code;
            mem_address_reg <= res.mem_address;
        end
    end

    assign reg_write       = reg_write_reg;
    assign write_index     = write_index_reg;
    assign write_value     = write_value_reg;
    assign jump_taken      = jump_taken_reg;
    assign jump_target     = jump_target_reg;
    assign skip_delay_slot = skip_reg;
    assign trap_code       = trap_reg;
    assign mem_address     = mem_address_reg;

`ifndef SYNTH
    // Register zero must never be marked as written.
    a_r0_never_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[0])
        else $error("register zero marked valid");

    // A result word with a trap never reports a register write.
    a_trap_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (trap_code != miu_pkg::TRAP_NONE) |-> !reg_write)
        else $error("write reported together with a trap");

    // The multiply/divide unit only finishes while the sequencer waits on it.
    a_md_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        md_done |-> state_reg == miu_pkg::ST_MD)
        else $error("multiply/divide finished outside its wait state");

    // Input and output sides are never open together.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result word is pending");

    // A reported write always names a register other than zero.
    a_write_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reg_write |-> write_index != 5'd0)
        else $error("write to register zero reported");
`endif

endmodule

/* test/mips32_integer_execute_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIPS32 integer execute unit testbench
// Feeds directed and random instruction words, keeps its own copy of the
// register file and HI/LO, and checks every result word field by field.
// ----------------------------------------------------------------------------
module mips32_integer_execute_unit_tb;
    import miu_pkg::*;

    typedef struct {
        logic [31:0] instr;
        logic [31:0] pc;
    } instr_word_t;

    typedef struct {
        logic        reg_write;
        logic [4:0]  write_index;
        logic [31:0] write_value;
        logic        jump_taken;
        logic [31:0] jump_target;
        logic        skip_delay_slot;
        logic [2:0]  trap_code;
        logic [31:0] mem_address;
    } exec_out_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] instruction_word;
    logic [31:0] program_counter;
    logic        out_valid;
    logic        out_ready;
    logic        reg_write;
    logic [4:0]  write_index;
    logic [31:0] write_value;
    logic        jump_taken;
    logic [31:0] jump_target;
    logic        skip_delay_slot;
    logic [2:0]  trap_code;
    logic [31:0] mem_address;

    // Shadow architectural state.
    logic [31:0] shadow_gpr [32];
    logic [31:0] shadow_hi;
    logic [31:0] shadow_lo;

    instr_word_t pending_words[$];
    exec_out_t   expected_results[$];
    int          mismatch_count;
    int          results_seen;
    int          send_gap;
    int          recv_gap;
    bit          stimulus_done;
    bit          drain_hold;

    mips32_integer_execute_unit DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .instruction_word (instruction_word),
        .program_counter  (program_counter),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .reg_write        (reg_write),
        .write_index      (write_index),
        .write_value      (write_value),
        .jump_taken       (jump_taken),
        .jump_target      (jump_target),
        .skip_delay_slot  (skip_delay_slot),
        .trap_code        (trap_code),
        .mem_address      (mem_address)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Mostly short gaps, occasionally a long one, often none at all.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("MISMATCH result %0d: %s got %08h expected %08h",
                 results_seen, field, got, want);
    endtask

    function automatic logic signed_less(logic [31:0] a, logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    // Computes the result word of one instruction and updates the shadow state.
    function automatic exec_out_t execute_instr(logic [31:0] w, logic [31:0] pc);
        exec_out_t   r;
        logic [5:0]  op;
        logic [5:0]  fn;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  sa;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] imm_zx;
        logic [31:0] imm_sx;
        logic [31:0] btgt;
        logic [31:0] sum;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] q;
        logic [31:0] rm;
        logic [63:0] prod;
        logic        neg;
        logic        cond;
        logic        likely;
        logic        is_branch;
        logic [4:0]  dest;
        logic [31:0] val;
        logic        wr;
        logic [31:0] align;

        r = '{default: '0};
        op = w[31:26];
        fn = w[5:0];
        rs = w[25:21];
        rt = w[20:16];
        rd = w[15:11];
        sa = w[10:6];
        x = shadow_gpr[rs];
        y = shadow_gpr[rt];
        imm_zx = {16'h0, w[15:0]};
        imm_sx = {{16{w[15]}}, w[15:0]};
        btgt = pc + 32'd4 + (imm_sx << 2);
        neg = x[31];
        wr = 1'b0;
        dest = '0;
        val = '0;
        cond = 1'b0;
        likely = 1'b0;
        is_branch = 1'b0;
        align = 32'd1;

        if (w != 32'h0)
        begin
            case (op)
                OP_SPECIAL:
                begin
                    case (fn)
                        FN_SLL:  begin wr = 1; dest = rd; val = y << sa; end
                        FN_SRL:  begin wr = 1; dest = rd; val = y >> sa; end
                        FN_SRA:  begin wr = 1; dest = rd; val = $signed(y) >>> sa; end
                        FN_SLLV: begin wr = 1; dest = rd; val = y << x[4:0]; end
                        FN_SRLV: begin wr = 1; dest = rd; val = y >> x[4:0]; end
                        FN_SRAV: begin wr = 1; dest = rd; val = $signed(y) >>> x[4:0]; end
                        FN_JR:   begin r.jump_taken = 1; r.jump_target = x; end
                        FN_JALR:
                        begin
                            // The target uses the source value read before the link.
                            r.jump_taken = 1; r.jump_target = x;
                            wr = 1; dest = rd; val = pc + 32'd8;
                        end
                        FN_SYSCALL: r.trap_code = TRAP_SYSCALL;
                        FN_BREAK:   r.trap_code = TRAP_BREAK;
                        FN_SYNC:    ;
                        FN_MFHI: begin wr = 1; dest = rd; val = shadow_hi; end
                        FN_MTHI: shadow_hi = x;
                        FN_MFLO: begin wr = 1; dest = rd; val = shadow_lo; end
                        FN_MTLO: shadow_lo = x;
                        FN_MULT:
                        begin
                            prod = $signed({{32{x[31]}}, x}) * $signed({{32{y[31]}}, y});
                            shadow_lo = prod[31:0]; shadow_hi = prod[63:32];
                        end
                        FN_MULTU:
                        begin
                            prod = {32'h0, x} * {32'h0, y};
                            shadow_lo = prod[31:0]; shadow_hi = prod[63:32];
                        end
                        FN_DIV:
                        begin
                            if (y == 0)
                            begin
                                shadow_lo = neg ? 32'd1 : 32'hffffffff;
                                shadow_hi = x;
                            end
                            else
                            begin
                                ax = neg ? -x : x;
                                ay = y[31] ? -y : y;
                                q = ax / ay;
                                rm = ax % ay;
                                shadow_lo = (neg != y[31]) ? -q : q;
                                shadow_hi = neg ? -rm : rm;
                            end
                        end
                        FN_DIVU:
                        begin
                            if (y == 0)
                            begin
                                shadow_lo = 32'hffffffff; shadow_hi = x;
                            end
                            else
                            begin
                                shadow_lo = x / y; shadow_hi = x % y;
                            end
                        end
                        FN_ADD:
                        begin
                            sum = x + y;
                            if (((x ^ sum) & (y ^ sum)) >> 31)
                                r.trap_code = TRAP_OVERFLOW;
                            else
                            begin
                                wr = 1; dest = rd; val = sum;
                            end
                        end
                        FN_ADDU: begin wr = 1; dest = rd; val = x + y; end
                        FN_SUB:
                        begin
                            sum = x - y;
                            if (((x ^ y) & (x ^ sum)) >> 31)
                                r.trap_code = TRAP_OVERFLOW;
                            else
                            begin
                                wr = 1; dest = rd; val = sum;
                            end
                        end
                        FN_SUBU: begin wr = 1; dest = rd; val = x - y; end
                        FN_AND:  begin wr = 1; dest = rd; val = x & y; end
                        FN_OR:   begin wr = 1; dest = rd; val = x | y; end
                        FN_XOR:  begin wr = 1; dest = rd; val = x ^ y; end
                        FN_NOR:  begin wr = 1; dest = rd; val = ~(x | y); end
                        FN_SLT:  begin wr = 1; dest = rd; val = {31'h0, signed_less(x, y)}; end
                        FN_SLTU: begin wr = 1; dest = rd; val = {31'h0, x < y}; end
                        default: r.trap_code = TRAP_RESERVED;
                    endcase
                end
                OP_REGIMM:
                begin
                    // Selector bit 4 links, bit 1 marks the likely form, bit 0 negates.
                    if (rt[3:2] != 2'b00 || rt[4] && rt[3])
                        r.trap_code = TRAP_RESERVED;
                    else
                    begin
                        is_branch = 1;
                        cond = rt[0] ? !neg : neg;
                        likely = rt[1];
                        if (rt[4])
                        begin
                            wr = 1; dest = 5'd31; val = pc + 32'd8;
                        end
                    end
                end
                OP_J, OP_JAL:
                begin
                    r.jump_taken = 1;
                    r.jump_target = ((pc + 32'd4) & 32'hf0000000) | {4'h0, w[25:0], 2'b00};
                    if (op == OP_JAL)
                    begin
                        wr = 1; dest = 5'd31; val = pc + 32'd8;
                    end
                end
                OP_BEQ, OP_BEQL:   begin is_branch = 1; cond = (x == y); likely = op[4]; end
                OP_BNE, OP_BNEL:   begin is_branch = 1; cond = (x != y); likely = op[4]; end
                OP_BLEZ, OP_BLEZL: begin is_branch = 1; cond = neg || x == 0; likely = op[4]; end
                OP_BGTZ, OP_BGTZL: begin is_branch = 1; cond = !neg && x != 0; likely = op[4]; end
                OP_ADDI:
                begin
                    sum = x + imm_sx;
                    if (((x ^ sum) & (imm_sx ^ sum)) >> 31)
                        r.trap_code = TRAP_OVERFLOW;
                    else
                    begin
                        wr = 1; dest = rt; val = sum;
                    end
                end
                OP_ADDIU: begin wr = 1; dest = rt; val = x + imm_sx; end
                OP_SLTI:  begin wr = 1; dest = rt; val = {31'h0, signed_less(x, imm_sx)}; end
                OP_SLTIU: begin wr = 1; dest = rt; val = {31'h0, x < imm_sx}; end
                OP_ANDI:  begin wr = 1; dest = rt; val = x & imm_zx; end
                OP_ORI:   begin wr = 1; dest = rt; val = x | imm_zx; end
                OP_XORI:  begin wr = 1; dest = rt; val = x ^ imm_zx; end
                OP_LUI:   begin wr = 1; dest = rt; val = {w[15:0], 16'h0}; end
                OP_COP1, OP_COP3, OP_LWC1, OP_LWC2, OP_LWC3, OP_SWC1, OP_SWC2, OP_SWC3:
                    r.trap_code = TRAP_COP;
                OP_LB, OP_LWL, OP_LBU, OP_LWR, OP_SB, OP_SWL, OP_SWR,
                OP_LH, OP_LHU, OP_SH, OP_LW, OP_LWU, OP_SW:
                begin
                    if (op == OP_LH || op == OP_LHU || op == OP_SH)
                        align = 32'd2;
                    else if (op == OP_LW || op == OP_LWU || op == OP_SW)
                        align = 32'd4;
                    r.mem_address = x + imm_sx;
                    if ((r.mem_address & (align - 1)) != 0)
                        r.trap_code = TRAP_MISALIGN;
                end
                OP_CACHE: ;
                default: r.trap_code = TRAP_RESERVED;
            endcase
        end

        if (is_branch)
        begin
            if (cond)
            begin
                r.jump_taken = 1; r.jump_target = btgt;
            end
            else if (likely)
                r.skip_delay_slot = 1;
        end

        // Writes to register 0 vanish and report nothing.
        if (wr && dest != 0)
        begin
            r.reg_write = 1;
            r.write_index = dest;
            r.write_value = val;
            shadow_gpr[dest] = val;
        end
        return r;
    endfunction

    function automatic logic [31:0] rtype(logic [4:0] s, logic [4:0] t, logic [4:0] d,
                                          logic [4:0] sh, logic [5:0] f);
        return {OP_SPECIAL, s, t, d, sh, f};
    endfunction

    function automatic logic [31:0] itype(logic [5:0] o, logic [4:0] s, logic [4:0] t,
                                          logic [15:0] imm);
        return {o, s, t, imm};
    endfunction

    task automatic queue_word(input logic [31:0] w, input logic [31:0] pc);
        pending_words.push_back('{instr: w, pc: pc});
    endtask

    // Operations that the random part favors; everything else comes from raw words.
    function automatic logic [31:0] random_instr();
        logic [5:0] ops [] = '{OP_REGIMM, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ,
            OP_BGTZ, OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI,
            OP_LUI, OP_BEQL, OP_BNEL, OP_BLEZL, OP_BGTZL, OP_LB, OP_LH, OP_LW, OP_LHU,
            OP_SH, OP_SW, OP_LWL, OP_SWR, OP_COP1, OP_LWC2};
        logic [5:0] fns [] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR,
            FN_JALR, FN_SYSCALL, FN_BREAK, FN_SYNC, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO,
            FN_MULT, FN_MULTU, FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU,
            FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
        logic [31:0] w;
        logic [15:0] imm;
        int          roll;
        w = $urandom;
        roll = $urandom_range(0, 99);
        // Registers 0..7 are reused often so that values flow between words.
        if ($urandom_range(0, 3) != 0)
        begin
            w[25:21] = $urandom_range(0, 7);
            w[20:16] = $urandom_range(0, 7);
            w[15:11] = $urandom_range(0, 7);
        end
        case ($urandom_range(0, 3))
            0: imm = 16'h0000;
            1: imm = 16'h8000 | $urandom_range(0, 3);
            2: imm = 16'h7ffc | $urandom_range(0, 3);
            default: imm = $urandom;
        endcase
        if (roll < 45)
            w = {OP_SPECIAL, w[25:6], fns[$urandom_range(0, fns.size() - 1)]};
        else if (roll < 90)
            w = {ops[$urandom_range(0, ops.size() - 1)], w[25:16], imm};
        else if (roll < 93)
            w[20:16] = $urandom_range(0, 3) == 0 ? w[20:16] : {2'b00, w[18], 2'b00} ^ w[20:16];
        // Remaining words stay fully random.
        return w;
    endfunction

    // Driver: pulls the next word from the queue after a random gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            instruction_word <= '0;
            program_counter <= '0;
            send_gap <= 0;
        end
        else if (in_valid && !in_ready)
        begin
            // Hold the word until it is accepted.
        end
        else
        begin
            if (in_valid && in_ready)
                expected_results.push_back(execute_instr(instruction_word, program_counter));
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_words.size() > 0 && !drain_hold)
            begin
                instr_word_t nw;
                nw = pending_words.pop_front();
                in_valid <= 1'b1;
                instruction_word <= nw.instr;
                program_counter <= nw.pc;
                send_gap <= pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: random back-pressure and result checking.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                exec_out_t e;
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    // A result word arrived with nothing outstanding.
                    report_mismatch("unexpected result word", 32'd1, 32'd0);
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (reg_write !== e.reg_write)
                        report_mismatch("reg_write", reg_write, e.reg_write);
                    if (write_index !== e.write_index)
                        report_mismatch("write_index", write_index, e.write_index);
                    if (write_value !== e.write_value)
                        report_mismatch("write_value", write_value, e.write_value);
                    if (jump_taken !== e.jump_taken)
                        report_mismatch("jump_taken", jump_taken, e.jump_taken);
                    if (jump_target !== e.jump_target)
                        report_mismatch("jump_target", jump_target, e.jump_target);
                    if (skip_delay_slot !== e.skip_delay_slot)
                        report_mismatch("skip_delay_slot", skip_delay_slot, e.skip_delay_slot);
                    if (trap_code !== e.trap_code)
                        report_mismatch("trap_code", trap_code, e.trap_code);
                    if (mem_address !== e.mem_address)
                        report_mismatch("mem_address", mem_address, e.mem_address);
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (out_valid && out_ready)
                    recv_gap <= pick_gap();
            end
        end
    end

    // Stimulus: directed words first, a full drain, then random words.
    initial
    begin
        logic [31:0] pc;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        instruction_word = '0;
        program_counter = '0;
        mismatch_count = 0;
        results_seen = 0;
        stimulus_done = 0;
        drain_hold = 0;
        for (int i = 0; i < 32; i++)
            shadow_gpr[i] = '0;
        shadow_hi = '0;
        shadow_lo = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Extremes into registers 1..3, then arithmetic corners.
        queue_word(itype(OP_LUI, 0, 1, 16'h8000), 32'h0);
        queue_word(itype(OP_ADDIU, 0, 2, 16'hffff), 32'h4);
        queue_word(itype(OP_LUI, 0, 3, 16'h7fff), 32'h8);
        queue_word(itype(OP_ORI, 3, 3, 16'hffff), 32'hc);
        queue_word(rtype(1, 2, 5, 0, FN_ADD), 32'h10);
        queue_word(rtype(1, 3, 5, 0, FN_SUB), 32'h14);
        queue_word(itype(OP_ADDI, 3, 6, 16'h0001), 32'h18);
        queue_word(rtype(0, 1, 0, 0, FN_SRA), 32'h1c);
        queue_word(rtype(0, 1, 7, 31, FN_SRA), 32'h20);
        queue_word(rtype(1, 2, 0, 0, FN_DIV), 32'h24);
        queue_word(rtype(0, 0, 8, 0, FN_MFLO), 32'h28);
        queue_word(rtype(1, 0, 0, 0, FN_DIV), 32'h2c);
        queue_word(rtype(0, 0, 8, 0, FN_MFHI), 32'h30);
        queue_word(rtype(3, 0, 0, 0, FN_DIVU), 32'h34);
        queue_word(rtype(1, 3, 0, 0, FN_MULT), 32'h38);
        queue_word(rtype(2, 2, 0, 0, FN_MULTU), 32'h3c);
        queue_word(rtype(3, 0, 3, 0, FN_JALR), 32'hfffffff8);
        queue_word({OP_JAL, 26'h3ffffff}, 32'hfffffffc);
        queue_word(itype(OP_REGIMM, 2, 5'h12, 16'h8000), 32'h40);
        queue_word(itype(OP_BGTZL, 1, 0, 16'h7fff), 32'h44);
        queue_word(itype(OP_LW, 2, 0, 16'h0003), 32'h48);
        queue_word(itype(OP_LH, 0, 0, 16'hffff), 32'h4c);
        queue_word(itype(OP_LWC1, 0, 0, 16'h0), 32'h50);
        queue_word(32'h0, 32'h54);
        queue_word(32'hffffffff, 32'h58);
        wait (pending_words.size() == 0 && !in_valid && expected_results.size() == 0);

        // Random programs with a walking PC, holding off once more mid-run.
        pc = $urandom & 32'hfffffffc;
        for (int n = 0; n < 1500; n++)
        begin
            if (n == 750)
            begin
                wait (pending_words.size() == 0);
                drain_hold = 1;
                wait (!in_valid && expected_results.size() == 0);
                drain_hold = 0;
            end
            if ($urandom_range(0, 15) == 0)
                pc = $urandom;
            queue_word(random_instr(), pc);
            pc = pc + 32'd4;
            if (pending_words.size() > 8)
                wait (pending_words.size() <= 4);
        end
        wait (pending_words.size() == 0 && !in_valid && expected_results.size() == 0);
        repeat (100) @(posedge clk);
        $display("Ran %0d instruction words: directed corners plus random ALU, branch,",
                 results_seen);
        $display("multiply/divide, load/store address, coprocessor and reserved words.");
        if (mismatch_count == 0)
            $display("mips32_integer_execute_unit_tb: done, clean");
        else
            $display("mips32_integer_execute_unit_tb: done, errors");
        $finish;
    end

    // Worst case is about 1525 words, each with long gaps on both sides.
    initial
    begin
        #2000000;
        $display("Timeout with %0d result words still expected", expected_results.size());
        $display("mips32_integer_execute_unit_tb: done, errors");
        $finish;
    end

endmodule
